// File: src/bcc_pkg.sv
// bcc_pkg: shared types and constants of the button click classifier
// holds mode and event codes, csr indexes and the state/config structs
// no dependencies

package bcc_pkg;

   // classifier modes
   typedef enum logic [2:0] {
      MODE_IDLE         = 3'd0,
      MODE_DEBOUNCE     = 3'd1,
      MODE_PRESSED      = 3'd2,
      MODE_WAIT_SECOND  = 3'd3,
      MODE_WAIT_RELEASE = 3'd4
   } mode_type;

   // reported events
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   // csr register indexes
   localparam int unsigned CsrIdxWidth = 8;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE     = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_PRESS   = 8'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_DOUBLE_CLICK = 8'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESSED_LVL  = 8'd3;

   // counter width and reset values of the registers
   localparam int unsigned TickWidth = 16;
   localparam logic [TickWidth-1:0] TICK_MAX         = 16'hFFFF;
   localparam logic [TickWidth-1:0] DEBOUNCE_RST     = 16'd20;
   localparam logic [TickWidth-1:0] LONG_PRESS_RST   = 16'd1000;
   localparam logic [TickWidth-1:0] DOUBLE_CLICK_RST = 16'd300;

   // classifier state
   typedef struct packed {
      mode_type               mode;
      logic [TickWidth-1:0]   tick_count;
      logic                   second_press;
   } state_type;

   // configuration registers
   typedef struct packed {
      logic [TickWidth-1:0] debounce_ticks;
      logic [TickWidth-1:0] long_press_ticks;
      logic [TickWidth-1:0] double_click_ticks;
      logic                 pressed_level;
   } cfg_type;

endpackage

// File: src/bcc_step.sv
// bcc_step: next state and event of the classifier for one level sample
// purely combinational; uses bcc_pkg for the state, config and event types

module bcc_step (
   input  bcc_pkg::state_type  state,
   input  bcc_pkg::cfg_type    cfg,
   input  logic                pin_level,
   output bcc_pkg::state_type  state_in,
   output bcc_pkg::event_type  event_res
);

   logic                            pressed;
   logic [bcc_pkg::TickWidth-1:0]   count_up;

   assign pressed = (pin_level == cfg.pressed_level);

   // saturating count
   assign count_up = (state.tick_count != bcc_pkg::TICK_MAX) ?
                     state.tick_count + bcc_pkg::TickWidth'(1) : state.tick_count;

   // next state
   always_comb begin
      state_in = state;
      unique case (state.mode)
         bcc_pkg::MODE_IDLE: begin
            if (pressed) begin
               state_in.mode       = bcc_pkg::MODE_DEBOUNCE;
               state_in.tick_count = '0;
            end
         end
         bcc_pkg::MODE_DEBOUNCE: begin
            state_in.tick_count = count_up;
            if (count_up >= cfg.debounce_ticks) begin
               state_in.tick_count = '0;
               if (pressed) begin
                  state_in.mode = bcc_pkg::MODE_PRESSED;
               end else begin
                  state_in.mode         = bcc_pkg::MODE_IDLE;
                  state_in.second_press = 1'b0;
               end
            end
         end
         bcc_pkg::MODE_PRESSED: begin
            if (!pressed) begin
               state_in.tick_count = '0;
               if (state.second_press) begin
                  state_in.mode         = bcc_pkg::MODE_IDLE;
                  state_in.second_press = 1'b0;
               end else begin
                  state_in.mode = bcc_pkg::MODE_WAIT_SECOND;
               end
            end else begin
               state_in.tick_count = count_up;
               if (count_up >= cfg.long_press_ticks) begin
                  // a long second press drops the pending first click
                  state_in.mode         = bcc_pkg::MODE_WAIT_RELEASE;
                  state_in.second_press = 1'b0;
               end
            end
         end
         bcc_pkg::MODE_WAIT_SECOND: begin
            state_in.tick_count = count_up;
            if (pressed) begin
               state_in.mode         = bcc_pkg::MODE_DEBOUNCE;
               state_in.tick_count   = '0;
               state_in.second_press = 1'b1;
            end else if (count_up >= cfg.double_click_ticks) begin
               state_in.mode       = bcc_pkg::MODE_IDLE;
               state_in.tick_count = '0;
            end
         end
         bcc_pkg::MODE_WAIT_RELEASE: begin
            if (!pressed) begin
               state_in.mode       = bcc_pkg::MODE_IDLE;
               state_in.tick_count = '0;
            end
         end
         default: begin
            // unused mode codes fall back to idle
            state_in.mode         = bcc_pkg::MODE_IDLE;
            state_in.tick_count   = '0;
            state_in.second_press = 1'b0;
         end
      endcase
   end

   // event output
   always_comb begin
      event_res = bcc_pkg::EV_NONE;
      unique case (state.mode)
         bcc_pkg::MODE_DEBOUNCE: begin
            // bounce on a second press still reports the first click
            if (count_up >= cfg.debounce_ticks && !pressed && state.second_press) begin
               event_res = bcc_pkg::EV_CLICK;
            end
         end
         bcc_pkg::MODE_PRESSED: begin
            if (!pressed && state.second_press) begin
               event_res = bcc_pkg::EV_DOUBLE;
            end
         end
         bcc_pkg::MODE_WAIT_SECOND: begin
            if (!pressed && count_up >= cfg.double_click_ticks) begin
               event_res = bcc_pkg::EV_CLICK;
            end
         end
         bcc_pkg::MODE_WAIT_RELEASE: begin
            if (!pressed) begin
               event_res = bcc_pkg::EV_LONG;
            end
         end
         default: begin
            event_res = bcc_pkg::EV_NONE;
         end
      endcase
   end

endmodule

// File: src/button_click_classifier.sv
// button_click_classifier: top level, handshakes, csr and pipeline registers
// depends on bcc_pkg and bcc_step
//
//  channel  | direction | handshake            | payload
//  req_     | in        | req_valid/req_ready  | req_pin_level (1 bit)
//  rsp_     | out       | rsp_valid/rsp_ready  | rsp_event_res (2 bit)
//  csr_     | in        | csr_valid/csr_ready  | csr_index (8 bit), csr_wdata (16 bit)
//
// one transaction per cycle sustained while rsp_ready stays high; each sample
// passes the input register, then goes through bcc_step into the result
// register. reset is synchronous and clears state, valid flags and csr
// registers to their defaults. a stalled rsp_ready holds the result
// register, and the input register fills before req_ready drops.
// csr writes are accepted every cycle; indexes beyond the list are ignored.

module button_click_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_pin_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_event_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [bcc_pkg::TickWidth-1:0]      csr_wdata
);

   bcc_pkg::cfg_type    cfg_ff;
   bcc_pkg::state_type  state_ff;
   bcc_pkg::state_type  state_in;
   bcc_pkg::event_type  event_in;
   logic                in_valid_ff;
   logic                in_pin_ff;
   logic                rsp_valid_ff;
   bcc_pkg::event_type  rsp_event_ff;
   logic                stage_adv;
   logic                out_free;

   // pipeline flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stage_adv = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || stage_adv;
   assign csr_ready = 1'b1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= bcc_pkg::DEBOUNCE_RST;
         cfg_ff.long_press_ticks   <= bcc_pkg::LONG_PRESS_RST;
         cfg_ff.double_click_ticks <= bcc_pkg::DOUBLE_CLICK_RST;
         cfg_ff.pressed_level      <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bcc_pkg::CSR_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_wdata;
            bcc_pkg::CSR_LONG_PRESS:   cfg_ff.long_press_ticks   <= csr_wdata;
            bcc_pkg::CSR_DOUBLE_CLICK: cfg_ff.double_click_ticks <= csr_wdata;
            bcc_pkg::CSR_PRESSED_LVL:  cfg_ff.pressed_level      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pin_ff <= req_pin_level;
      end
   end

   // classifier step
   bcc_step u_step (
      .state     (state_ff),
      .cfg       (cfg_ff),
      .pin_level (in_pin_ff),
      .state_in  (state_in),
      .event_res (event_in)
   );

   // classifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= bcc_pkg::MODE_IDLE;
         state_ff.tick_count   <= '0;
         state_ff.second_press <= 1'b0;
      end else if (stage_adv) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_event_ff <= event_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;

   // second press is pending only while debouncing or pressed
   a_second_press_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.second_press |->
         (state_ff.mode == bcc_pkg::MODE_DEBOUNCE || state_ff.mode == bcc_pkg::MODE_PRESSED))
      else $error("second_press set outside debounce/pressed");

   // state moves only with a transaction leaving the input register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !stage_adv |=> $stable(state_ff))
      else $error("classifier state changed without a transaction");

   // a new result comes only from an advancing sample
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_adv))
      else $error("result appeared without a sample");

   // a long press, reported on leaving wait-release, returns to idle with a cleared count
   a_long_source: assert property (@(posedge clock) disable iff (reset)
      stage_adv && event_in == bcc_pkg::EV_LONG |=>
         state_ff.mode == bcc_pkg::MODE_IDLE && state_ff.tick_count == '0)
      else $error("long press did not return to idle");

endmodule
